// ===== design/mpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_pkg
// Types, register indexes and reset values shared by the moisture pump
// controller modules.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int SECONDS_WIDTH_DEFAULT = 16;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CONFIRM_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TICKS_PER_SECOND = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_IRRIGATE     = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD_OFF         = 2'd3;

  localparam logic [7:0]  CONFIRM_COUNT_RESET    = 8'd10;
  localparam logic [7:0]  TICKS_PER_SECOND_RESET = 8'd20;
  localparam logic [15:0] MAX_IRRIGATE_RESET     = 16'd120;
  localparam logic [15:0] HOLD_OFF_RESET         = 16'd600;

  typedef enum logic [1:0] {
    MODE_MONITOR  = 2'd0,
    MODE_IRRIGATE = 2'd1,
    MODE_HOLD     = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0]  confirm_count;
    logic [7:0]  ticks_per_second;
    logic [15:0] max_irrigate_seconds;
    logic [15:0] hold_off_seconds;
  } cfg_t;

  typedef struct packed {
    logic       pump_on;
    logic [1:0] mode;
    logic       filtered_dry;
  } result_t;

endpackage

// ===== design/mpc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_cfg_regs
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
module mpc_cfg_regs
  import mpc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm_count        <= CONFIRM_COUNT_RESET;
      cfg.ticks_per_second     <= TICKS_PER_SECOND_RESET;
      cfg.max_irrigate_seconds <= MAX_IRRIGATE_RESET;
      cfg.hold_off_seconds     <= HOLD_OFF_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CONFIRM_COUNT:    cfg.confirm_count        <= cfg_data[7:0];
        CFG_TICKS_PER_SECOND: cfg.ticks_per_second     <= cfg_data[7:0];
        CFG_MAX_IRRIGATE:     cfg.max_irrigate_seconds <= cfg_data;
        CFG_HOLD_OFF:         cfg.hold_off_seconds     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/mpc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_core
// Controller state and its single-pass update: seconds timer, sensor
// debounce filter and mode sequencing, one item per update.
// ----------------------------------------------------------------------------
module mpc_core
  import mpc_pkg::*;
#(
  parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    load,
  input  logic    sample,
  output result_t result_next
);

  localparam int CMP_WIDTH = (SECONDS_WIDTH > 16) ? SECONDS_WIDTH : 16;

  mode_t                    current_mode, current_mode_next;
  logic [7:0]               sub_tick_count, sub_tick_count_next;
  logic [SECONDS_WIDTH-1:0] elapsed_seconds, elapsed_seconds_next;
  logic [7:0]               mismatch_run, mismatch_run_next;
  logic                     stable_level, stable_level_next;

  logic [7:0]               sub_inc;
  logic                     second_done;
  logic [SECONDS_WIDTH-1:0] seconds_adv;
  logic [CMP_WIDTH-1:0]     seconds_cmp;
  logic                     irrigate_limit;
  logic                     hold_done;
  logic [7:0]               run_inc;
  logic                     level_match;
  logic                     level_accept;
  logic                     db_level;
  logic [7:0]               db_run;
  logic                     pump;

  always_comb begin
    sub_inc     = sub_tick_count + 8'd1;
    second_done = (sub_inc >= cfg.ticks_per_second);
    seconds_adv = second_done ? elapsed_seconds + SECONDS_WIDTH'(1) : elapsed_seconds;
    seconds_cmp = CMP_WIDTH'(seconds_adv);
    irrigate_limit = (seconds_cmp >= CMP_WIDTH'(cfg.max_irrigate_seconds));
    hold_done      = (seconds_cmp >= CMP_WIDTH'(cfg.hold_off_seconds));

    level_match  = (sample == stable_level);
    run_inc      = mismatch_run + 8'd1;
    level_accept = !level_match && (run_inc >= cfg.confirm_count);
    db_level     = level_accept ? sample : stable_level;
    db_run       = (level_match || level_accept) ? 8'd0 : run_inc;
  end

  always_comb begin
    sub_tick_count_next  = second_done ? 8'd0 : sub_inc;
    elapsed_seconds_next = seconds_adv;
    mismatch_run_next    = mismatch_run;
    stable_level_next    = stable_level;
    current_mode_next    = current_mode;
    pump                 = 1'b0;
    case (current_mode)
      MODE_MONITOR: begin
        mismatch_run_next = db_run;
        stable_level_next = db_level;
        if (db_level) begin
          elapsed_seconds_next = '0;
          current_mode_next    = MODE_IRRIGATE;
        end
      end
      MODE_IRRIGATE: begin
        pump              = 1'b1;
        mismatch_run_next = db_run;
        stable_level_next = db_level;
        if (!db_level || irrigate_limit) begin
          elapsed_seconds_next = '0;
          current_mode_next    = MODE_HOLD;
        end
      end
      MODE_HOLD: begin
        if (hold_done) begin
          current_mode_next = MODE_MONITOR;
        end
      end
      default: begin
        current_mode_next = MODE_MONITOR;
      end
    endcase
  end

  always_comb begin
    result_next.pump_on      = pump;
    result_next.mode         = current_mode_next;
    result_next.filtered_dry = stable_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode    <= MODE_MONITOR;
      sub_tick_count  <= 8'd0;
      elapsed_seconds <= '0;
      mismatch_run    <= 8'd0;
      stable_level    <= 1'b0;
    end else if (load) begin
      current_mode    <= current_mode_next;
      sub_tick_count  <= sub_tick_count_next;
      elapsed_seconds <= elapsed_seconds_next;
      mismatch_run    <= mismatch_run_next;
      stable_level    <= stable_level_next;
    end
  end

endmodule

// ===== design/mpc_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_out_reg
// Result register with valid and ready; takes a new item whenever it is
// empty or its current item is taken in the same cycle.
// ----------------------------------------------------------------------------
module mpc_out_reg
  import mpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= in_data;
    end
  end

endmodule

// ===== design/moisture_pump_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moisture_pump_controller
// Output: an accepted tick item's result is registered, ready the next cycle.
// Throughput: one item per cycle unless results stall; the result register
// frees itself as its item is taken, so ready depends only on the output side.
// Reset: synchronous; mode monitor, counters cleared, filtered level wet,
// configuration registers back to their default values.
// ----------------------------------------------------------------------------
module moisture_pump_controller
  import mpc_pkg::*;
#(
  parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       sensor_dry,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       pump_on,
  output logic [1:0]                 mode,
  output logic                       filtered_dry,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t result_next;
  result_t result;
  logic    load;

  assign load = in_valid && in_ready;

  mpc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mpc_core #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .load        (load),
    .sample      (sensor_dry),
    .result_next (result_next)
  );

  mpc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (result_next),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (result)
  );

  assign pump_on      = result.pump_on;
  assign mode         = result.mode;
  assign filtered_dry = result.filtered_dry;

endmodule

// ===== bench/pump_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_result_checker
// Watches the tick, result and register write channels of the moisture pump
// controller. It keeps its own copy of the controller state and registers,
// works out the result of every accepted tick item and compares each
// accepted result item, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module pump_result_checker
  import mpc_pkg::*;
#(
  parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       sensor_dry,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       pump_on,
  input  logic [1:0]                 mode,
  input  logic                       filtered_dry,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                         failures,
  output int                         waiting
);

  logic [7:0]               confirm_reg;
  logic [7:0]               tps_reg;
  logic [15:0]              max_reg;
  logic [15:0]              hold_reg;

  mode_t                    mode_q;
  logic [7:0]               tick_cnt;
  logic [SECONDS_WIDTH-1:0] secs;
  logic [7:0]               diff_run;
  logic                     level;

  result_t                  pending_results [$];
  int                       fail_total = 0;

  assign failures = fail_total;

  function automatic logic filter_sample(input logic dry);
    if (dry == level) begin
      diff_run = '0;
    end else begin
      diff_run = diff_run + 8'd1;
      if (diff_run >= confirm_reg) begin
        diff_run = '0;
        level = dry;
      end
    end
    return level;
  endfunction

  function automatic result_t advance_tick(input logic dry);
    result_t r;
    mode_t   start;
    logic    kept;
    start = mode_q;
    r = '0;
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt >= tps_reg) begin
      tick_cnt = '0;
      secs = secs + 1'b1;
    end
    case (start)
      MODE_MONITOR: begin
        if (filter_sample(dry)) begin
          secs = '0;
          mode_q = MODE_IRRIGATE;
        end
      end
      MODE_IRRIGATE: begin
        r.pump_on = 1'b1;
        kept = filter_sample(dry);
        if (!kept || secs >= max_reg) begin
          secs = '0;
          mode_q = MODE_HOLD;
        end
      end
      MODE_HOLD: begin
        if (secs >= hold_reg) mode_q = MODE_MONITOR;
      end
      default: begin
        mode_q = MODE_MONITOR;
      end
    endcase
    r.mode = mode_q;
    r.filtered_dry = level;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      confirm_reg = CONFIRM_COUNT_RESET;
      tps_reg = TICKS_PER_SECOND_RESET;
      max_reg = MAX_IRRIGATE_RESET;
      hold_reg = HOLD_OFF_RESET;
      mode_q = MODE_MONITOR;
      tick_cnt = '0;
      secs = '0;
      diff_run = '0;
      level = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONFIRM_COUNT:    confirm_reg = cfg_data[7:0];
          CFG_TICKS_PER_SECOND: tps_reg = cfg_data[7:0];
          CFG_MAX_IRRIGATE:     max_reg = cfg_data;
          CFG_HOLD_OFF:         hold_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) begin
            $display("%0t: unexpected result: pump_on=%0b mode=%0d filtered_dry=%0b",
                     $realtime, pump_on, mode, filtered_dry);
          end
        end else begin
          want = pending_results.pop_front();
          if (pump_on !== want.pump_on || mode !== want.mode ||
              filtered_dry !== want.filtered_dry) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("%0t: expected pump_on=%0b mode=%0d filtered_dry=%0b",
                       $realtime, want.pump_on, want.mode, want.filtered_dry);
              $display("%0t:   actual pump_on=%0b mode=%0d filtered_dry=%0b",
                       $realtime, pump_on, mode, filtered_dry);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(advance_tick(sensor_dry));
      end
    end
    waiting <= pending_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives tick items and register writes into the moisture pump controller
// under several register settings and idling patterns, and reports the
// verdict of the checker that sits beside it.
// ----------------------------------------------------------------------------
module tb_top
  import mpc_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       sensor_dry = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       pump_on;
  logic [1:0]                 mode;
  logic                       filtered_dry;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  int                         failures;
  int                         waiting;
  int unsigned                cycles = 0;
  int                         idle_pct = 0;
  int                         stall_pct = 0;
  int                         cur_confirm = CONFIRM_COUNT_RESET;

  moisture_pump_controller dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sensor_dry   (sensor_dry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pump_on      (pump_on),
    .mode         (mode),
    .filtered_dry (filtered_dry),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pump_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sensor_dry   (sensor_dry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pump_on      (pump_on),
    .mode         (mode),
    .filtered_dry (filtered_dry),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .waiting      (waiting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_idling(input idling_t how);
    case (how)
      IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin idle_pct = 63; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 63; end
      default:       begin idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  task automatic send_tick(input logic dry);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      sensor_dry <= 1'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sensor_dry <= dry;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_bits(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(bits[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] c, input logic [7:0] t,
                              input logic [15:0] m, input logic [15:0] h);
    logic [CFG_INDEX_WIDTH-1:0] idx_list [4];
    logic [CFG_DATA_WIDTH-1:0]  val_list [4];
    idx_list = '{CFG_CONFIRM_COUNT, CFG_TICKS_PER_SECOND, CFG_MAX_IRRIGATE, CFG_HOLD_OFF};
    val_list = '{{8'($urandom), c}, {8'($urandom), t}, m, h};
    cur_confirm = c;
    cfg_valid <= 1'b1;
    foreach (idx_list[i]) begin
      cfg_index <= idx_list[i];
      cfg_data <= val_list[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic feed_runs(input int n);
    int   left;
    int   len;
    logic lvl;
    left = n;
    lvl = 1'($urandom);
    while (left > 0) begin
      if ($urandom_range(99) < 70) begin
        len = cur_confirm + $urandom_range(cur_confirm + 8);
      end else begin
        len = $urandom_range(cur_confirm > 1 ? cur_confirm - 1 : 1, 1);
      end
      if (len < 1) len = 1;
      for (int i = 0; i < len && left > 0; i++) begin
        send_tick(($urandom_range(99) < 3) ? !lvl : lvl);
        left--;
      end
      lvl = !lvl;
    end
  endtask

  initial begin
    logic [7:0]  c;
    logic [7:0]  t;
    logic [15:0] m;
    logic [15:0] h;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_idling(IDLE_NONE);
    send_bits(32'b010110, 6);
    settle();
    program_regs(8'd0, 8'd0, 16'd3, 16'd0);
    send_bits(32'b111100101110, 12);
    settle();
    program_regs(8'd1, 8'd1, 16'd2, 16'd0);
    send_bits(32'b1011001, 7);

    for (int p = 0; p < 8; p++) begin
      c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5));
      t = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4));
      m = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 1)) : 16'($urandom_range(12, 1));
      h = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8));
      settle();
      program_regs(c, t, m, h);
      set_idling(idling_t'(p % 4));
      feed_runs(100);
    end

    settle();
    program_regs(8'd1, 8'd1, 16'd1, 16'd0);
    set_idling(IDLE_BOTH);
    feed_runs(150);

    settle();
    program_regs(8'd255, 8'd255, 16'd65535, 16'd65535);
    set_idling(IDLE_SENDER);
    feed_runs(600);

    settle();
    program_regs(8'd1, 8'd0, 16'd2, 16'd0);
    set_idling(IDLE_NONE);
    send_bits(32'b111101, 6);

    settle();
    repeat (4) @(posedge clk);
    if (failures == 0 && waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mpc_pkg.sv
design/mpc_cfg_regs.sv
design/mpc_core.sv
design/mpc_out_reg.sv
design/moisture_pump_controller.sv
bench/pump_result_checker.sv
bench/tb_top.sv
